// ----- hdl/spq_pkg.sv -----
// Shared types and constants for the stable min-priority queue.
`default_nettype none

package spq_pkg;

    // Default number of entries the queue can hold.
    localparam int DEPTH_DEFAULT = 16;

    // Width of a stored value and of a stored priority.
    localparam int DATA_W = 32;

    // Command codes carried by an input transaction.
    typedef enum logic [1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_DUMP = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    // Status codes carried by a result transaction.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // One stored entry as it sits in the entry memory.
    typedef struct packed {
        logic signed [DATA_W-1:0] pri;
        logic signed [DATA_W-1:0] val;
    } entry_t;

    localparam int ENTRY_W = 2 * DATA_W;

endpackage

`default_nettype wire

// ----- hdl/stable_min_priority_queue.sv -----
// Enqueue appends at the tail and goes straight to the result; dequeue makes a scan pass for the
// minimum and a shift pass over the later slots. Dump: one full pass over the entry memory per emitted entry.
// The single read port of the entry memory sets this pacing; one command at a time.
// An input transaction is taken only in the idle state; the output register holds one result.
// Reset (rst_n low, asynchronous) empties the queue and clears the output valid flag.
`default_nettype none

module stable_min_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_stall,
    input  wire logic [1:0]                         cmd,
    input  wire logic signed [spq_pkg::DATA_W-1:0]  item_value,
    input  wire logic signed [spq_pkg::DATA_W-1:0]  item_priority,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic signed [spq_pkg::DATA_W-1:0]       out_value,
    output logic signed [spq_pkg::DATA_W-1:0]       out_priority,
    output logic [1:0]                              status,
    output logic                                    last_of_run
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEQ_SCAN,
        S_DEQ_SHIFT,
        S_DUMP_SCAN,
        S_EMIT
    } state_t;

    state_t                            state_reg,      state_next;
    logic [CNT_W-1:0]                  count_reg,      count_next;
    logic [CNT_W-1:0]                  k_reg,          k_next;
    logic                              pend_reg,       pend_next;
    logic [IDX_W-1:0]                  pend_addr_reg,  pend_addr_next;
    logic                              found_reg,      found_next;
    logic signed [spq_pkg::DATA_W-1:0] best_val_reg,   best_val_next;
    logic signed [spq_pkg::DATA_W-1:0] best_pri_reg,   best_pri_next;
    logic [IDX_W-1:0]                  best_idx_reg,   best_idx_next;
    logic                              have_last_reg,  have_last_next;
    logic signed [spq_pkg::DATA_W-1:0] last_pri_reg,   last_pri_next;
    logic [IDX_W-1:0]                  last_idx_reg,   last_idx_next;
    logic [CNT_W-1:0]                  emitted_reg,    emitted_next;
    logic                              more_reg,       more_next;
    logic signed [spq_pkg::DATA_W-1:0] res_val_reg,    res_val_next;
    logic signed [spq_pkg::DATA_W-1:0] res_pri_reg,    res_pri_next;
    spq_pkg::status_t                  res_status_reg, res_status_next;
    logic                              res_last_reg,   res_last_next;
    logic                              out_valid_reg,  out_valid_next;
    logic signed [spq_pkg::DATA_W-1:0] out_val_reg,    out_val_next;
    logic signed [spq_pkg::DATA_W-1:0] out_pri_reg,    out_pri_next;
    spq_pkg::status_t                  out_status_reg, out_status_next;
    logic                              out_last_reg,   out_last_next;

    logic             accept;
    spq_pkg::cmd_t    cmd_code;
    logic             is_full;
    logic             is_empty;
    logic             scanning;
    logic             issue;
    logic             pass_done;
    logic             eligible;
    logic             take;
    logic             out_load;
    logic             last_pick;
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    spq_pkg::entry_t  ram_wr_data;
    spq_pkg::entry_t  rd_entry;
    logic [spq_pkg::ENTRY_W-1:0] rd_word;

    // Entry memory, kept in arrival order.
    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (k_reg[IDX_W-1:0]),
        .rd_data (rd_word)
    );

    assign rd_entry = spq_pkg::entry_t'(rd_word);

    // Input handshake and queue occupancy.
    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign cmd_code   = spq_pkg::cmd_t'(cmd);
    assign is_full    = (count_reg == CNT_W'(DEPTH));
    assign is_empty   = (count_reg == '0);

    // A read is issued each cycle of a scan or shift until the last entry has been addressed.
    // The data of the read issued in the previous cycle is flagged by pend_reg.
    assign scanning  = (state_reg == S_DEQ_SCAN) || (state_reg == S_DUMP_SCAN)
                       || (state_reg == S_DEQ_SHIFT);
    assign issue     = scanning && (k_reg < count_reg);
    assign pass_done = (k_reg == count_reg) && !pend_reg;

    // A dump pass only considers entries that sort after the one emitted last,
    // ordering by priority first and arrival slot second.
    assign eligible = !have_last_reg
                      || (rd_entry.pri > last_pri_reg)
                      || ((rd_entry.pri == last_pri_reg) && (pend_addr_reg > last_idx_reg));

    // Scanning in slot order with a strict compare keeps the earliest of equal priorities.
    assign take = pend_reg
                  && ((state_reg == S_DEQ_SCAN) || eligible)
                  && (!found_reg || (rd_entry.pri < best_pri_reg));

    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || !result_stall);
    assign last_pick = ((emitted_reg + CNT_W'(1)) == count_reg);

    // Memory writes: enqueue appends at the tail; the shift moves each later entry down one slot.
    // The shift writes two slots below the one it reads, so no forwarding is needed.
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = count_reg[IDX_W-1:0];
        ram_wr_data = '{pri: item_priority, val: item_value};
        if (state_reg == S_DEQ_SHIFT)
        begin
            ram_wr_en   = pend_reg;
            ram_wr_addr = IDX_W'(pend_addr_reg - IDX_W'(1));
            ram_wr_data = rd_entry;
        end
        else if (accept && (cmd_code == spq_pkg::CMD_ENQ) && !is_full)
        begin
            ram_wr_en = 1'b1;
        end
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        pend_next       = issue;
        pend_addr_next  = k_reg[IDX_W-1:0];
        found_next      = found_reg;
        best_val_next   = best_val_reg;
        best_pri_next   = best_pri_reg;
        best_idx_next   = best_idx_reg;
        have_last_next  = have_last_reg;
        last_pri_next   = last_pri_reg;
        last_idx_next   = last_idx_reg;
        emitted_next    = emitted_reg;
        more_next       = more_reg;
        res_val_next    = res_val_reg;
        res_pri_next    = res_pri_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        out_val_next    = out_val_reg;
        out_pri_next    = out_pri_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && result_stall;

        // Address counter shared by all scan and shift states; running minimum kept by the two scan states.
        if (issue)
        begin
            k_next = k_reg + CNT_W'(1);
        end
        if (take && (state_reg != S_DEQ_SHIFT))
        begin
            found_next    = 1'b1;
            best_val_next = rd_entry.val;
            best_pri_next = rd_entry.pri;
            best_idx_next = pend_addr_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_val_next  = '0;
                    res_pri_next  = '0;
                    res_last_next = 1'b1;
                    more_next     = 1'b0;
                    k_next        = '0;
                    found_next    = 1'b0;
                    case (cmd_code)
                        spq_pkg::CMD_ENQ:
                        begin
                            if (is_full)
                            begin
                                res_status_next = spq_pkg::ST_FULL;
                            end
                            else
                            begin
                                res_status_next = spq_pkg::ST_OK;
                                count_next      = count_reg + CNT_W'(1);
                            end
                            state_next = S_EMIT;
                        end
                        spq_pkg::CMD_DEQ:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = spq_pkg::ST_EMPTY;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_DEQ_SCAN;
                            end
                        end
                        spq_pkg::CMD_DUMP:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = spq_pkg::ST_EMPTY;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                have_last_next = 1'b0;
                                emitted_next   = '0;
                                state_next     = S_DUMP_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_DEQ_SCAN:
            begin
                if (pass_done)
                begin
                    k_next     = CNT_W'(best_idx_reg) + CNT_W'(1);
                    state_next = S_DEQ_SHIFT;
                end
            end

            S_DEQ_SHIFT:
            begin
                if (pass_done)
                begin
                    count_next      = count_reg - CNT_W'(1);
                    res_val_next    = best_val_reg;
                    res_pri_next    = best_pri_reg;
                    res_status_next = spq_pkg::ST_OK;
                    res_last_next   = 1'b1;
                    more_next       = 1'b0;
                    state_next      = S_EMIT;
                end
            end

            S_DUMP_SCAN:
            begin
                if (pass_done)
                begin
                    res_val_next    = best_val_reg;
                    res_pri_next    = best_pri_reg;
                    res_status_next = spq_pkg::ST_OK;
                    res_last_next   = last_pick;
                    more_next       = !last_pick;
                    have_last_next  = 1'b1;
                    last_pri_next   = best_pri_reg;
                    last_idx_next   = best_idx_reg;
                    emitted_next    = emitted_reg + CNT_W'(1);
                    state_next      = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_val_next    = res_val_reg;
                    out_pri_next    = res_pri_reg;
                    out_status_next = res_status_reg;
                    out_last_next   = res_last_reg;
                    k_next          = '0;
                    found_next      = 1'b0;
                    state_next      = more_reg ? S_DUMP_SCAN : S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            have_last_reg <= 1'b0;
            emitted_reg   <= '0;
            more_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            have_last_reg <= have_last_next;
            emitted_reg   <= emitted_next;
            more_reg      <= more_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_addr_reg  <= pend_addr_next;
        best_val_reg   <= best_val_next;
        best_pri_reg   <= best_pri_next;
        best_idx_reg   <= best_idx_next;
        last_pri_reg   <= last_pri_next;
        last_idx_reg   <= last_idx_next;
        res_val_reg    <= res_val_next;
        res_pri_reg    <= res_pri_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
        out_val_reg    <= out_val_next;
        out_pri_reg    <= out_pri_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign result_valid = out_valid_reg;
    assign out_value    = out_val_reg;
    assign out_priority = out_pri_reg;
    assign status       = out_status_reg;
    assign last_of_run  = out_last_reg;

endmodule

`default_nettype wire

// ----- hdl/spq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module spq_ram #(
    parameter int WIDTH = spq_pkg::ENTRY_W,
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hdl/spq_checker.sv -----
// Port-level assertions for the stable min-priority queue, bound to the top level.
`default_nettype none

module spq_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               item_valid,
    input wire logic                               item_stall,
    input wire logic [1:0]                         cmd,
    input wire logic                               result_valid,
    input wire logic                               result_stall,
    input wire logic signed [spq_pkg::DATA_W-1:0]  out_value,
    input wire logic signed [spq_pkg::DATA_W-1:0]  out_priority,
    input wire logic [1:0]                         status,
    input wire logic                               last_of_run
);

    // No result is offered on the first edge after reset is released.
    assert property (@(posedge clk) $rose(rst_n) |-> !result_valid)
        else $error("result offered right after reset");

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(out_value) && $stable(out_priority)
            && $stable(status) && $stable(last_of_run))
        else $error("stalled result changed");

    // A full or empty report carries zero fields and closes its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != spq_pkg::ST_OK) |->
            (out_value == '0) && (out_priority == '0) && last_of_run)
        else $error("error result with nonzero payload or open run");

    // Every real command keeps the input side busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (cmd != spq_pkg::CMD_NONE) |=> item_stall)
        else $error("input taken again before the command finished");

endmodule

bind stable_min_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire
